FILE: sv/sal_pkg.sv
// Shared types and constants for the shifting array list.
// No dependencies; imported by every module of the block.
`default_nettype none

package sal_pkg;

  // List geometry
  localparam int LIST_DEPTH = 16;
  localparam int WORD_W     = 32;
  localparam int POS_W      = 4;
  localparam int ENTRY_W    = 5;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  // Common width for comparing positions, counts and cell indexes
  localparam int PTR_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Request codes
  typedef enum logic [1:0] {
    REQ_INS_AT  = 2'd0,
    REQ_DEL_AT  = 2'd1,
    REQ_INS_END = 2'd2,
    REQ_DEL_END = 2'd3
  } sal_req_t;

  // Decoded request from the control unit
  typedef struct packed {
    logic             ins;  // insert that will be applied
    logic             del;  // delete that will be applied
    logic [PTR_W-1:0] pos;  // effective list position
  } sal_op_t;

  // Per-cell load controls
  typedef struct packed {
    logic load_val;    // take the inserted word
    logic shift_up;    // take the lower neighbor's word
    logic shift_down;  // take the upper neighbor's word
  } sal_cell_ctl_t;

endpackage

`default_nettype wire

FILE: sv/shifting_array_list_top.sv
// Shifting array list top level: control, a row of slot cells, result register.
// Depends on sal_pkg, sal_ctrl and sal_cell.
//
//   channel | direction | handshake        | payload
//   in_     | input     | in_valid/in_stall | req_type, position, value
//   out_    | output    | out_valid/out_stall | removed_value, applied,
//           |           |                  |   entry_count, is_empty, is_full
//
// Each word is decoded, and the cells from its position up load the inserted
// word or a shifted neighbor in the accepting edge; the result shows next cycle.
// One word per cycle is taken while out_stall is low; the single result
// register holds in_stall high while its word waits to be taken.
// Reset (synchronous, rst_n low) empties the list; slot contents are not cleared.
`default_nettype none

module shifting_array_list_top
  import sal_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_req_type,
  input  wire logic [POS_W-1:0]   in_position,
  input  wire logic signed [WORD_W-1:0] in_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [WORD_W-1:0] out_removed_value,
  output logic                    out_applied,
  output logic [ENTRY_W-1:0]      out_entry_count,
  output logic                    out_is_empty,
  output logic                    out_is_full
);

  logic                     accept;
  sal_op_t                  op;
  logic [CNT_W-1:0]         cnt_r;
  logic [CNT_W-1:0]         cnt_nxt;
  logic [WORD_W-1:0]        slot_word [LIST_DEPTH];
  sal_cell_ctl_t            cell_ctl  [LIST_DEPTH];
  logic [WORD_W-1:0]        taken;

  logic                     out_valid_r;
  logic                     out_valid_nxt;
  logic [WORD_W-1:0]        removed_r;
  logic                     applied_r;
  logic [CNT_W-1:0]         res_cnt_r;

  // Handshake
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  sal_ctrl u_ctrl (
    .req_type (in_req_type),
    .position (in_position),
    .cnt      (cnt_r),
    .op       (op)
  );

  // Row of slot cells; each decides its own load from the effective position
  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic [WORD_W-1:0] prev_w;
    logic [WORD_W-1:0] next_w;

    assign cell_ctl[i].load_val   = accept && op.ins && (PTR_W'(i) == op.pos);
    assign cell_ctl[i].shift_up   = accept && op.ins && (PTR_W'(i) >  op.pos);
    assign cell_ctl[i].shift_down = accept && op.del && (PTR_W'(i) >= op.pos);

    if (i == 0) begin : g_first
      assign prev_w = '0;
    end else begin : g_mid_lo
      assign prev_w = slot_word[i-1];
    end
    if (i == LIST_DEPTH - 1) begin : g_last
      assign next_w = '0;
    end else begin : g_mid_hi
      assign next_w = slot_word[i+1];
    end

    sal_cell u_cell (
      .clk       (clk),
      .ctl       (cell_ctl[i]),
      .prev_word (prev_w),
      .next_word (next_w),
      .ins_word  (in_value),
      .word      (slot_word[i])
    );
  end

  // Word leaving on a delete: OR of the selected cell
  always_comb begin
    taken = '0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      if (op.del && (PTR_W'(i) == op.pos)) begin
        taken = taken | slot_word[i];
      end
    end
  end

  // Entry count
  always_comb begin
    cnt_nxt = cnt_r;
    if (accept && op.ins) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (accept && op.del) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  assign out_valid_nxt = accept ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (accept) begin
      removed_r <= taken;
      applied_r <= op.ins || op.del;
      res_cnt_r <= cnt_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_removed_value = removed_r;
  assign out_applied       = applied_r;
  assign out_entry_count   = ENTRY_W'(res_cnt_r);
  assign out_is_empty      = (res_cnt_r == '0);
  assign out_is_full       = (res_cnt_r == CNT_W'(LIST_DEPTH));

endmodule

`default_nettype wire

FILE: sv/sal_ctrl.sv
// Request decode: effective position and accept/refuse decision.
// Depends on sal_pkg.
`default_nettype none

module sal_ctrl
  import sal_pkg::*;
(
  input  wire logic [1:0]       req_type,
  input  wire logic [POS_W-1:0] position,
  input  wire logic [CNT_W-1:0] cnt,
  output sal_op_t               op
);

  logic [PTR_W-1:0] cnt_ext;
  logic             is_ins;
  logic [PTR_W-1:0] pos;
  logic             full;

  assign cnt_ext = PTR_W'(cnt);
  assign full    = (cnt == CNT_W'(LIST_DEPTH));

  // Map request code to kind and position
  always_comb begin
    is_ins = 1'b0;
    pos    = '0;
    unique case (sal_req_t'(req_type))
      REQ_INS_AT: begin
        is_ins = 1'b1;
        pos    = PTR_W'(position);
      end
      REQ_DEL_AT: begin
        pos    = PTR_W'(position);
      end
      REQ_INS_END: begin
        is_ins = 1'b1;
        pos    = cnt_ext;
      end
      REQ_DEL_END: begin
        pos    = cnt_ext - PTR_W'(1);
      end
      default: begin
        pos    = '0;
      end
    endcase
  end

  // Insert needs room and no gap; delete needs an occupied slot
  assign op.ins = is_ins  && !full && (pos <= cnt_ext);
  assign op.del = !is_ins && (cnt != '0) && (pos < cnt_ext);
  assign op.pos = pos;

endmodule

`default_nettype wire

FILE: sv/sal_cell.sv
// One slot of the list: holds a word and loads the inserted word or a neighbor's.
// Depends on sal_pkg.
`default_nettype none

module sal_cell
  import sal_pkg::*;
(
  input  wire logic              clk,
  input  wire sal_cell_ctl_t     ctl,
  input  wire logic [WORD_W-1:0] prev_word,
  input  wire logic [WORD_W-1:0] next_word,
  input  wire logic [WORD_W-1:0] ins_word,
  output logic      [WORD_W-1:0] word
);

  logic [WORD_W-1:0] word_r;
  logic [WORD_W-1:0] word_nxt;

  // Select the slot's next word
  always_comb begin
    if (ctl.load_val) begin
      word_nxt = ins_word;
    end else if (ctl.shift_up) begin
      word_nxt = prev_word;
    end else if (ctl.shift_down) begin
      word_nxt = next_word;
    end else begin
      word_nxt = word_r;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;

endmodule

`default_nettype wire

FILE: sv/sal_checker.sv
// Port-level checks for the shifting array list, bound to the top level.
// Depends on sal_pkg and shifting_array_list_top.
`default_nettype none

module sal_checker
  import sal_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [WORD_W-1:0]  out_removed_value,
  input wire logic               out_applied,
  input wire logic [ENTRY_W-1:0] out_entry_count,
  input wire logic               out_is_empty,
  input wire logic               out_is_full
);

  // A result that is stalled stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  // Every accepted word yields a result on the next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted word produced no result");

  // Empty flag agrees with the count
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_entry_count == '0)))
    else $error("empty flag disagrees with entry count");

  // A list cannot be both empty and full
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_is_empty && out_is_full))
    else $error("empty and full together");

  // Refused requests return a zero word
  a_refused: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_applied |-> (out_removed_value == '0))
    else $error("refused request returned a word");

endmodule

bind shifting_array_list_top sal_checker u_sal_checker (.*);

`default_nettype wire
